// ----- rtl/core/gnd_pkg.sv -----
// Shared types, constants and window helpers for the grid neighbourhood diff block.
`default_nettype none

package gnd_pkg;

    localparam int COORD_W       = 6;
    localparam int FIELD_LIMIT   = 64;
    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_GRID_ROWS = 64;
    localparam int WIN_SLOTS     = 9;
    localparam int NUM_SLOTS     = 2 * WIN_SLOTS;
    localparam int SLOT_W        = 5;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 16;

    typedef logic [COORD_W-1:0]        t_coord;
    typedef logic signed [COORD_W+1:0] t_scoord;
    typedef logic [NUM_SLOTS-1:0]      t_slot_mask;
    typedef logic [3:0]                t_win_slot;

    typedef enum logic {
        KIND_REMOVE = 1'b0,
        KIND_ADD    = 1'b1
    } t_kind;

    typedef struct packed {
        logic   old_valid;
        t_coord old_x;
        t_coord old_y;
        t_coord cur_x;
        t_coord cur_y;
    } t_req;

    // base + off - 1, off in 0..2
    function automatic t_scoord nbr_coord(t_coord base, logic [1:0] off);
        t_scoord b;
        t_scoord o;
        b = t_scoord'({2'b00, base});
        o = t_scoord'({6'b000000, off});
        return b + o - t_scoord'(1);
    endfunction

    function automatic logic [1:0] slot_row(t_win_slot slot);
        logic [1:0] r;
        unique case (slot)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] slot_col(t_win_slot slot);
        logic [1:0] c;
        unique case (slot)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gnd_mask.sv -----
// Slot mask of removed and added cells for one request.
`default_nettype none

module gnd_mask #(
    parameter int GRID_COLS = gnd_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = gnd_pkg::DEF_GRID_ROWS
) (
    input  gnd_pkg::t_req       i_req,
    output gnd_pkg::t_slot_mask o_mask
);
    import gnd_pkg::*;

    localparam int LIM_COLS = (GRID_COLS < FIELD_LIMIT) ? GRID_COLS : FIELD_LIMIT;
    localparam int LIM_ROWS = (GRID_ROWS < FIELD_LIMIT) ? GRID_ROWS : FIELD_LIMIT;

    // cell of window A at slot, inside grid and not covered by window B
    function automatic logic slot_hit(logic va, t_coord ax, t_coord ay,
                                      logic vb, t_coord bx, t_coord by,
                                      t_win_slot slot);
        t_scoord x;
        t_scoord y;
        t_scoord dx;
        t_scoord dy;
        logic    in_grid;
        logic    in_b;
        x = nbr_coord(ax, slot_col(slot));
        y = nbr_coord(ay, slot_row(slot));
        in_grid = (x >= t_scoord'(0)) && (x < t_scoord'(LIM_COLS))
               && (y >= t_scoord'(0)) && (y < t_scoord'(LIM_ROWS));
        dx = x - t_scoord'({2'b00, bx});
        dy = y - t_scoord'({2'b00, by});
        in_b = vb && (dx >= -t_scoord'(1)) && (dx <= t_scoord'(1))
                  && (dy >= -t_scoord'(1)) && (dy <= t_scoord'(1));
        return va && in_grid && !in_b;
    endfunction

    always_comb begin
        o_mask = '0;
        for (int s = 0; s < WIN_SLOTS; s++) begin
            o_mask[s] = slot_hit(i_req.old_valid, i_req.old_x, i_req.old_y,
                                 1'b1, i_req.cur_x, i_req.cur_y, t_win_slot'(s));
            o_mask[s + WIN_SLOTS] = slot_hit(1'b1, i_req.cur_x, i_req.cur_y,
                                             i_req.old_valid, i_req.old_x, i_req.old_y,
                                             t_win_slot'(s));
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/grid_neighbourhood_diff.sv -----
// Top level: 3x3 area-of-interest difference between an old and a current grid cell.
`default_nettype none

// A request carries an old cell (tuser = old cell valid) and a current cell. The block
// answers with the cells leaving view (tuser = 0) in row-major order of the old window,
// then the cells entering view (tuser = 1) in row-major order of the current window,
// windows being 3x3 and clipped to the grid; tlast marks the final one. A request's
// results (0 to 18 of them) leave one per cycle while the receiver holds tready high,
// from a single output register, and the next request is taken in the cycle its
// predecessor's last result moves to that register. Requests that yield nothing are
// taken every cycle. No results come out for an unchanged valid cell.

module grid_neighbourhood_diff #(
    parameter int GRID_COLS = gnd_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = gnd_pkg::DEF_GRID_ROWS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: old_x[5:0], old_y[11:6], cur_x[17:12], cur_y[23:18]
    input  wire logic [gnd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: old_valid
    input  wire logic                           i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: cell_x[5:0], cell_y[11:6], zero[15:12]
    output logic [gnd_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // tuser: kind
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);
    import gnd_pkg::*;

    t_req       req_in;
    t_slot_mask new_mask;

    t_slot_mask r_mask;
    t_coord     r_ox, r_oy, r_cx, r_cy;

    logic       r_out_valid;
    t_kind      r_out_kind;
    t_coord     r_out_x, r_out_y;
    logic       r_out_last;

    t_slot_mask sel, rest;
    logic [SLOT_W-1:0] idx;
    t_win_slot  slot;
    t_kind      kind;
    t_coord     base_x, base_y;
    t_scoord    cell_x, cell_y;
    logic       busy, advance, accept;

    assign req_in.old_valid = i_s_tuser;
    assign req_in.old_x     = i_s_tdata[5:0];
    assign req_in.old_y     = i_s_tdata[11:6];
    assign req_in.cur_x     = i_s_tdata[17:12];
    assign req_in.cur_y     = i_s_tdata[23:18];

    gnd_mask #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_mask (
        .i_req  (req_in),
        .o_mask (new_mask)
    );

    // lowest pending slot goes out next
    assign sel  = r_mask & (~r_mask + t_slot_mask'(1));
    assign rest = r_mask & ~sel;

    always_comb begin
        idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (sel[i]) begin
                idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (idx >= SLOT_W'(WIN_SLOTS)) begin
            kind   = KIND_ADD;
            slot   = t_win_slot'(idx - SLOT_W'(WIN_SLOTS));
            base_x = r_cx;
            base_y = r_cy;
        end else begin
            kind   = KIND_REMOVE;
            slot   = t_win_slot'(idx);
            base_x = r_ox;
            base_y = r_oy;
        end
        cell_x = nbr_coord(base_x, slot_col(slot));
        cell_y = nbr_coord(base_y, slot_row(slot));
    end

    assign busy       = |r_mask;
    assign advance    = busy && (!r_out_valid || i_m_tready);
    assign o_s_tready = !busy || (advance && (rest == '0));
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mask <= new_mask;
            end else if (advance) begin
                r_mask <= rest;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ox <= req_in.old_x;
            r_oy <= req_in.old_y;
            r_cx <= req_in.cur_x;
            r_cy <= req_in.cur_y;
        end
        if (advance) begin
            r_out_kind <= kind;
            r_out_x    <= cell_x[COORD_W-1:0];
            r_out_y    <= cell_y[COORD_W-1:0];
            r_out_last <= (rest == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - 2 * COORD_W){1'b0}}, r_out_y, r_out_x};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/core/gnd_checker.sv -----
// Port-level checks for the grid neighbourhood diff block, bound to the top level.
`default_nettype none

module gnd_checker #(
    parameter int GRID_COLS = gnd_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = gnd_pkg::DEF_GRID_ROWS
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic [gnd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input wire logic                           i_s_tuser,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [gnd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                           o_m_tuser,
    input wire logic                           o_m_tlast
);
    import gnd_pkg::*;

    localparam int LIM_COLS = (GRID_COLS < FIELD_LIMIT) ? GRID_COLS : FIELD_LIMIT;
    localparam int LIM_ROWS = (GRID_ROWS < FIELD_LIMIT) ? GRID_ROWS : FIELD_LIMIT;

    // waiting request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && !o_s_tready) |=> (i_s_tvalid && $stable(i_s_tdata)
            && $stable(i_s_tuser)))
        else $error("request changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("result changed while stalled");

    // no new request while a request's results are still pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast && !i_m_tready) |-> !o_s_tready)
        else $error("request taken before previous results drained");

    // reported cells lie inside the grid
    a_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((32'(o_m_tdata[5:0]) < LIM_COLS)
            && (32'(o_m_tdata[11:6]) < LIM_ROWS) && (o_m_tdata[15:12] == 4'd0)))
        else $error("reported cell outside grid");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind grid_neighbourhood_diff gnd_checker #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
) u_gnd_checker (.*);

`default_nettype wire

// ----- tb/sv/grid_neighbourhood_diff_tb.sv -----
// Self-checking testbench for grid_neighbourhood_diff: random moves, stream stalls, result check.
`timescale 1ns / 1ps

module grid_neighbourhood_diff_tb;
    import gnd_pkg::*;

    localparam int GRID_W = DEF_GRID_COLS;
    localparam int GRID_H = DEF_GRID_ROWS;
    localparam int PAD_W  = OUT_DATA_W - 2 * COORD_W;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } t_phase;

    typedef struct {
        t_kind  kind;
        t_coord x;
        t_coord y;
        logic   last;
    } t_view_change;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    t_req         moves_q[$];
    t_view_change changes_q[$];
    t_phase       phase = PH_FREE;
    logic         req_taken = 1'b0;
    int           n_taken = 0;
    int           n_err = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    grid_neighbourhood_diff dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic bit in_view(bit v, int cx, int cy, int x, int y);
        return v && x >= 0 && y >= 0 && x < GRID_W && y < GRID_H &&
               x - cx >= -1 && x - cx <= 1 && y - cy >= -1 && y - cy <= 1;
    endfunction

    // cells of window a that window b does not cover, row-major
    task automatic queue_window_diff(bit va, int ax, int ay, bit vb, int bx, int by,
                                     t_kind k);
        t_view_change c;
        int x;
        int y;
        if (!va)
            return;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                x = ax + dx;
                y = ay + dy;
                if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H)
                    continue;
                if (in_view(vb, bx, by, x, y))
                    continue;
                c.kind = k;
                c.x    = t_coord'(x);
                c.y    = t_coord'(y);
                c.last = 1'b0;
                changes_q.insert(changes_q.size(), c);
            end
        end
    endtask

    task automatic predict_view_changes(t_req r);
        int n0;
        n0 = changes_q.size();
        queue_window_diff(r.old_valid, r.old_x, r.old_y, 1'b1, r.cur_x, r.cur_y, KIND_REMOVE);
        queue_window_diff(1'b1, r.cur_x, r.cur_y, r.old_valid, r.old_x, r.old_y, KIND_ADD);
        if (changes_q.size() > n0)
            changes_q[changes_q.size() - 1].last = 1'b1;
    endtask

    task automatic add_move(bit v, int ox, int oy, int cx, int cy);
        t_req r;
        r.old_valid = v;
        r.old_x     = t_coord'(ox);
        r.old_y     = t_coord'(oy);
        r.cur_x     = t_coord'(cx);
        r.cur_y     = t_coord'(cy);
        moves_q.insert(moves_q.size(), r);
    endtask

    function automatic int pick_coord(int lim);
        int e;
        if ($urandom_range(3) == 0) begin
            e = $urandom_range(3);
            return (e < 2) ? e : lim - 4 + e;
        end
        return $urandom_range(lim - 1);
    endfunction

    function automatic int clamp(int v, int lim);
        return (v < 0) ? 0 : (v >= lim) ? lim - 1 : v;
    endfunction

    task automatic add_random_moves(int n);
        int sel;
        int cx;
        int cy;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            cx  = pick_coord(GRID_W);
            cy  = pick_coord(GRID_H);
            if (sel < 10)
                add_move(1'b0, $urandom_range(63), $urandom_range(63), cx, cy);
            else if (sel < 20)
                add_move(1'b1, cx, cy, cx, cy);
            else if (sel < 35)
                add_move(1'b1, $urandom_range(63), $urandom_range(63), cx, cy);
            else
                add_move(1'b1, cx, cy,
                         clamp(cx + $urandom_range(4) - 2, GRID_W),
                         clamp(cy + $urandom_range(4) - 2, GRID_H));
        end
    endtask

    task automatic note_mismatch(string what, t_view_change c);
        n_err++;
        if (n_err <= 10)
            $display("%s: exp kind %0d x %0d y %0d last %0d, ",
                     what, c.kind, c.x, c.y, c.last,
                     "got tuser %0d x %0d y %0d pad %h last %0d",
                     o_m_tuser, o_m_tdata[COORD_W-1:0],
                     o_m_tdata[2*COORD_W-1:COORD_W], o_m_tdata[OUT_DATA_W-1:2*COORD_W],
                     o_m_tlast);
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_req r;
        bit   idle;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || req_taken) begin
            idle = (phase == PH_SRC_IDLE && $urandom_range(99) < 51) ||
                   (phase == PH_BOTH && $urandom_range(99) < 14);
            if (moves_q.size() != 0 && !idle) begin
                r = moves_q.pop_front();
                i_s_tdata  <= {r.cur_y, r.cur_x, r.old_y, r.old_x};
                i_s_tuser  <= r.old_valid;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off once, while requests keep coming
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_taken >= 12) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge i_clk) begin
        bit stall;
        stall = (phase == PH_SNK_STALL && $urandom_range(99) < 51) ||
                (phase == PH_BOTH && $urandom_range(99) < 14);
        i_m_tready <= i_rst_n && hold_left == 0 && !stall;
    end

    // monitor: check results first, then predict for a newly taken request
    always @(posedge i_clk) begin
        t_view_change c;
        t_req         r;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                if (changes_q.size() == 0) begin
                    c = '{KIND_REMOVE, '0, '0, 1'b0};
                    note_mismatch("unexpected result", c);
                end else begin
                    c = changes_q.pop_front();
                    if (o_m_tuser !== c.kind || o_m_tlast !== c.last ||
                        o_m_tdata !== {{PAD_W{1'b0}}, c.y, c.x})
                        note_mismatch("mismatch", c);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                r = {i_s_tuser, i_s_tdata[5:0], i_s_tdata[11:6], i_s_tdata[17:12],
                     i_s_tdata[23:18]};
                predict_view_changes(r);
                n_taken++;
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_move(1'b0, 0, 0, 0, 0);
        add_move(1'b0, 63, 63, 63, 63);
        add_move(1'b0, 42, 21, 31, 31);
        add_move(1'b1, 31, 31, 31, 31);
        add_move(1'b1, 0, 63, 0, 63);
        add_move(1'b1, 31, 31, 32, 31);
        add_move(1'b1, 32, 31, 31, 31);
        add_move(1'b1, 31, 31, 31, 30);
        add_move(1'b1, 31, 30, 31, 31);
        add_move(1'b1, 31, 31, 32, 32);
        add_move(1'b1, 32, 32, 31, 30);
        add_move(1'b1, 10, 10, 12, 12);
        add_move(1'b1, 0, 0, 63, 63);
        add_move(1'b1, 63, 63, 0, 0);
        add_move(1'b1, 0, 0, 1, 0);
        add_move(1'b1, 63, 0, 62, 1);
        add_move(1'b1, 5, 5, 40, 50);
        add_move(1'b1, 62, 63, 63, 63);
        add_move(1'b1, 0, 32, 63, 32);
        add_move(1'b1, 21, 42, 42, 21);
        add_move(1'b1, 1, 1, 0, 0);
        add_move(1'b1, 62, 62, 63, 63);

        for (int p = 0; p < 4; p++) begin
            phase = t_phase'(p);
            add_random_moves(32);
            while (moves_q.size() != 0)
                @(posedge i_clk);
        end

        while (changes_q.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (n_err == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
